// ===== rtl/cfps_pkg.sv =====
// ---------------------------------------------------------------------------
// cfps_pkg
// Widths, constants and lane types for the cube-face to panorama sampler.
// ---------------------------------------------------------------------------
package cfps_pkg;

   // field widths
   localparam int FACE_W = 3;
   localparam int PIX_W  = 10;
   localparam int DIM_W  = 14;
   localparam int SRC_W  = 13;
   localparam int OFS_W  = 26;
   localparam int IDX_W  = 2;

   // source and face limits
   localparam logic [DIM_W-1:0] MAX_SOURCE_DIM = 14'd8192;
   localparam int               FSZ_W          = 11;
   localparam logic [FSZ_W-1:0] MIN_FACE_SIZE  = 11'd64;
   localparam logic [FSZ_W-1:0] MAX_FACE_SIZE  = 11'd1024;

   // face coordinate divider: quotient of (2p+1)*2^16 / F, one bit per stage
   localparam int Q_W        = 17;
   localparam int DIV_STAGES = Q_W;
   localparam int DIR_W      = 18;
   localparam logic signed [DIR_W-1:0] ONE_Q16 = 18'sd65536;

   // square root of dx^2 + dz^2, two radicand bits per stage
   localparam int SQ_W        = 34;
   localparam int SQRT_STAGES = SQ_W / 2;
   localparam int ROOT_W      = SQRT_STAGES;
   localparam int SREM_W      = ROOT_W + 2;

   // CORDIC vectoring
   localparam int CORDIC_ITERATIONS = 20;
   localparam int CX_W     = 34;
   localparam int Z_W      = 34;
   localparam int PRESCALE_SHIFT = 12;
   localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;

   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   // input register, divider, direction, square, root, pre-rotate,
   // CORDIC, angle map, scale, clamp, output
   localparam int PIPE_DEPTH = 1 + DIV_STAGES + 2 + SQRT_STAGES + 1
                               + CORDIC_ITERATIONS + 4;

   // register indexes
   localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   typedef struct packed {
      logic [FSZ_W-1:0] rem;
      logic [Q_W-1:0]   q;
   } div_lane_type;

   typedef struct packed {
      logic [SREM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [SQ_W-1:0]   s;
   } sqrt_lane_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   zero;
   } cordic_lane_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] dx;
      logic signed [DIR_W-1:0] dy;
      logic signed [DIR_W-1:0] dz;
   } dir_type;

endpackage

// ===== rtl/cubemap_face_to_panorama_sampler.sv =====
// ---------------------------------------------------------------------------
// cubemap_face_to_panorama_sampler
// Maps a cube-face output pixel to its nearest equirectangular source pixel.
// ---------------------------------------------------------------------------
// Usage:
//   Requests (req_face, req_pixel_x, req_pixel_y) enter on a valid/ready
//   channel; each yields one response (rsp_source_x, rsp_source_y,
//   rsp_pixel_offset, rsp_fill_black). Source width and height are written
//   through the csr channel (index 0 width, index 1 height) while no
//   request is in flight; csr_ready is always high.
//   The pipeline is PIPE_DEPTH = 62 registers deep, and rsp_valid is the
//   valid bit of its last register; a request passes through all of
//   them before its response is offered.
//   Throughput is one request per cycle while the receiver does not stall:
//   the pipeline is a 17-stage face coordinate divider, a 17-stage square
//   root and a 20-stage CORDIC with both angles in parallel lanes, plus
//   eight stages of setup, angle mapping, scaling and output.
//   When the receiver stalls with a response waiting, the whole pipeline
//   holds and req_ready drops; nothing is lost or repeated.
//   Reset (synchronous) clears all stage valid bits and both size
//   registers, so the block reports an empty source (black fill) until
//   the sizes are written.
// ---------------------------------------------------------------------------
module cubemap_face_to_panorama_sampler
   import cfps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [FACE_W-1:0] req_face,
   input  logic [PIX_W-1:0]  req_pixel_x,
   input  logic [PIX_W-1:0]  req_pixel_y,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [SRC_W-1:0] rsp_source_x,
   output logic [SRC_W-1:0] rsp_source_y,
   output logic [OFS_W-1:0] rsp_pixel_offset,
   output logic             rsp_fill_black,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0] csr_data
);

   // ---- step functions ----
   function automatic div_lane_type div_step(input div_lane_type d, input logic nb,
                                             input logic [FSZ_W-1:0] fs);
      logic [FSZ_W:0] t;
      div_lane_type   r;
      t = {d.rem, nb};
      if (t >= {1'b0, fs}) begin
         r.rem = FSZ_W'(t - {1'b0, fs});
         r.q   = {d.q[Q_W-2:0], 1'b1};
      end else begin
         r.rem = t[FSZ_W-1:0];
         r.q   = {d.q[Q_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic sqrt_lane_type sqrt_step(input sqrt_lane_type d);
      logic [SREM_W+1:0] t;
      logic [SREM_W+1:0] trial;
      sqrt_lane_type     r;
      t     = {d.rem, d.s[SQ_W-1 -: 2]};
      trial = (SREM_W+2)'({d.root, 2'b01});
      r.s   = {d.s[SQ_W-3:0], 2'b00};
      if (t >= trial) begin
         r.rem  = SREM_W'(t - trial);
         r.root = {d.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = SREM_W'(t);
         r.root = {d.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic cordic_lane_type prerotate(input logic signed [CX_W-1:0] y,
                                                 input logic signed [CX_W-1:0] x);
      logic signed [CX_W-1:0] xs;
      logic signed [CX_W-1:0] ys;
      cordic_lane_type        r;
      xs     = x <<< PRESCALE_SHIFT;
      ys     = y <<< PRESCALE_SHIFT;
      r.zero = (x == '0) && (y == '0);
      r.x    = xs;
      r.y    = ys;
      r.z    = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            r.x = ys;
            r.y = -xs;
            r.z = QUARTER_TURN;
         end else begin
            r.x = -ys;
            r.y = xs;
            r.z = -QUARTER_TURN;
         end
      end
      return r;
   endfunction

   function automatic cordic_lane_type cordic_step(input cordic_lane_type c,
                                                   input int i);
      logic signed [CX_W-1:0] xs;
      logic signed [CX_W-1:0] ys;
      logic signed [Z_W-1:0]  a;
      cordic_lane_type        r;
      xs     = c.x >>> i;
      ys     = c.y >>> i;
      a      = signed'(Z_W'(ATAN_TURNS[i]));
      r.zero = c.zero;
      if (c.y > 0) begin
         r.x = c.x + ys;
         r.y = c.y - xs;
         r.z = c.z + a;
      end else begin
         r.x = c.x - ys;
         r.y = c.y + xs;
         r.z = c.z - a;
      end
      return r;
   endfunction

   // ---- configuration ----
   logic [DIM_W-1:0] width_ff, height_ff;
   logic [DIM_W-1:0] wc, hc;
   logic [FSZ_W-1:0] fsz;
   logic             empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == REG_SOURCE_WIDTH) width_ff <= csr_data;
         if (csr_index == REG_SOURCE_HEIGHT) height_ff <= csr_data;
      end
   end

   always_comb begin
      wc    = (width_ff > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : width_ff;
      hc    = (height_ff > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : height_ff;
      empty = (width_ff == '0) || (height_ff == '0);
      if (height_ff < DIM_W'(MIN_FACE_SIZE)) fsz = MIN_FACE_SIZE;
      else if (height_ff > DIM_W'(MAX_FACE_SIZE)) fsz = MAX_FACE_SIZE;
      else fsz = FSZ_W'(height_ff);
   end

   // ---- pipeline control: the whole pipe advances together ----
   logic                  en;
   logic [PIPE_DEPTH-1:0] vld_ff;

   assign en        = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // ---- stage registers ----
   logic [FACE_W-1:0]  a_face_ff;
   logic [PIX_W-1:0]   a_px_ff, a_py_ff;
   logic [PIX_W-1:0]   a_px_in, a_py_in;

   div_lane_type       dv_x_ff [DIV_STAGES];
   div_lane_type       dv_y_ff [DIV_STAGES];
   div_lane_type       dv_x_in [DIV_STAGES];
   div_lane_type       dv_y_in [DIV_STAGES];
   logic [FACE_W-1:0]  dv_face_ff [DIV_STAGES];

   dir_type            e_dir_ff, e_dir_in;
   dir_type            f_dir_ff;
   logic [SQ_W-1:0]    f_sq_ff, f_sq_in;

   sqrt_lane_type      sq_ff [SQRT_STAGES];
   sqrt_lane_type      sq_in [SQRT_STAGES];
   dir_type            sq_dir_ff [SQRT_STAGES];

   cordic_lane_type    az_ff [CORDIC_ITERATIONS+1];
   cordic_lane_type    el_ff [CORDIC_ITERATIONS+1];
   cordic_lane_type    az_in [CORDIC_ITERATIONS+1];
   cordic_lane_type    el_in [CORDIC_ITERATIONS+1];

   logic [31:0]        u_ff, u_in;
   logic [32:0]        v_ff, v_in;
   logic [DIM_W-1:0]   m_sx_ff, m_sx_in;
   logic [DIM_W:0]     m_sy_ff, m_sy_in;
   logic [SRC_W-1:0]   k_sx_ff, k_sx_in, k_sy_ff, k_sy_in;

   logic [SRC_W-1:0]   rsp_sx_ff, rsp_sy_ff;
   logic [OFS_W-1:0]   rsp_ofs_ff, rsp_ofs_in;
   logic               rsp_fill_ff;

   // ---- datapath next values ----
   always_comb begin
      div_lane_type           dprev_x, dprev_y;
      sqrt_lane_type          sprev;
      logic [Q_W-1:0]         qx, qy;
      logic signed [DIR_W-1:0] fx, fy;
      logic signed [2*DIR_W-1:0] p1, p2;
      logic signed [Z_W-1:0]  az, el;
      logic signed [Z_W+1:0]  v36;
      logic [45:0]            prod_x;
      logic [46:0]            prod_y;
      logic [DIM_W-1:0]       wm1, hm1;
      logic [2*DIM_W-1:0]     ofs;

      // clamp pixel to the face
      a_px_in = ({1'b0, req_pixel_x} >= fsz) ? PIX_W'(fsz - 1'b1) : req_pixel_x;
      a_py_in = ({1'b0, req_pixel_y} >= fsz) ? PIX_W'(fsz - 1'b1) : req_pixel_y;

      // restoring divider, numerator is {p, 1, zeros}
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            dprev_x.rem = FSZ_W'(a_px_ff);
            dprev_x.q   = '0;
            dprev_y.rem = FSZ_W'(a_py_ff);
            dprev_y.q   = '0;
         end else begin
            dprev_x = dv_x_ff[k-1];
            dprev_y = dv_y_ff[k-1];
         end
         dv_x_in[k] = div_step(dprev_x, (k == 0), fsz);
         dv_y_in[k] = div_step(dprev_y, (k == 0), fsz);
      end

      // face coordinates and direction
      qx = dv_x_ff[DIV_STAGES-1].q;
      qy = dv_y_ff[DIV_STAGES-1].q;
      fx = signed'({1'b0, qx}) - ONE_Q16;
      fy = signed'({1'b0, qy}) - ONE_Q16;
      case (dv_face_ff[DIV_STAGES-1])
         FACE_POS_X: e_dir_in = '{dx: ONE_Q16,  dy: -fy,      dz: -fx};
         FACE_NEG_X: e_dir_in = '{dx: -ONE_Q16, dy: -fy,      dz: fx};
         FACE_POS_Y: e_dir_in = '{dx: fx,       dy: ONE_Q16,  dz: fy};
         FACE_NEG_Y: e_dir_in = '{dx: fx,       dy: -ONE_Q16, dz: -fy};
         FACE_POS_Z: e_dir_in = '{dx: fx,       dy: -fy,      dz: ONE_Q16};
         default:    e_dir_in = '{dx: -fx,      dy: -fy,      dz: -ONE_Q16};
      endcase

      // horizontal radius squared
      p1      = e_dir_ff.dx * e_dir_ff.dx;
      p2      = e_dir_ff.dz * e_dir_ff.dz;
      f_sq_in = SQ_W'(p1) + SQ_W'(p2);

      // digit-by-digit square root
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            sprev.rem  = '0;
            sprev.root = '0;
            sprev.s    = f_sq_ff;
         end else begin
            sprev = sq_ff[k-1];
         end
         sq_in[k] = sqrt_step(sprev);
      end

      // CORDIC lanes: azimuth atan2(dx,dz), elevation atan2(dy,r)
      az_in[0] = prerotate(CX_W'(sq_dir_ff[SQRT_STAGES-1].dx),
                           CX_W'(sq_dir_ff[SQRT_STAGES-1].dz));
      el_in[0] = prerotate(CX_W'(sq_dir_ff[SQRT_STAGES-1].dy),
                           signed'(CX_W'({1'b0, sq_ff[SQRT_STAGES-1].root})));
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
         az_in[i+1] = cordic_step(az_ff[i], i);
         el_in[i+1] = cordic_step(el_ff[i], i);
      end

      // angles to panorama u (wrapped) and v (clamped)
      az   = az_ff[CORDIC_ITERATIONS].zero ? '0 : az_ff[CORDIC_ITERATIONS].z;
      el   = el_ff[CORDIC_ITERATIONS].zero ? '0 : el_ff[CORDIC_ITERATIONS].z;
      u_in = az[31:0] ^ 32'h8000_0000;
      v36  = (Z_W+2)'(36'sd2147483648) - ((Z_W+2)'(el) <<< 1);
      if (v36 < 0) v_in = '0;
      else if (v36 > (Z_W+2)'(36'sd4294967296)) v_in = 33'h1_0000_0000;
      else v_in = v36[32:0];

      // scale to source size
      prod_x  = u_ff * wc;
      prod_y  = v_ff * hc;
      m_sx_in = prod_x[45:32];
      m_sy_in = prod_y[46:32];

      // limit to last column and row
      wm1     = wc - 1'b1;
      hm1     = hc - 1'b1;
      k_sx_in = (m_sx_ff > wm1) ? SRC_W'(wm1) : SRC_W'(m_sx_ff);
      k_sy_in = (m_sy_ff > {1'b0, hm1}) ? SRC_W'(hm1) : SRC_W'(m_sy_ff);

      // linear offset
      ofs        = (2*DIM_W)'(k_sy_ff) * (2*DIM_W)'(wc) + (2*DIM_W)'(k_sx_ff);
      rsp_ofs_in = ofs[OFS_W-1:0];
   end

   // ---- stage register updates ----
   always_ff @(posedge clock) begin
      if (en) begin
         a_face_ff <= req_face;
         a_px_ff   <= a_px_in;
         a_py_ff   <= a_py_in;
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_x_ff[k]    <= dv_x_in[k];
            dv_y_ff[k]    <= dv_y_in[k];
            dv_face_ff[k] <= (k == 0) ? a_face_ff : dv_face_ff[(k == 0) ? 0 : k-1];
         end
         e_dir_ff <= e_dir_in;
         f_dir_ff <= e_dir_ff;
         f_sq_ff  <= f_sq_in;
         for (int k = 0; k < SQRT_STAGES; k++) begin
            sq_ff[k]     <= sq_in[k];
            sq_dir_ff[k] <= (k == 0) ? f_dir_ff : sq_dir_ff[(k == 0) ? 0 : k-1];
         end
         for (int i = 0; i <= CORDIC_ITERATIONS; i++) begin
            az_ff[i] <= az_in[i];
            el_ff[i] <= el_in[i];
         end
         u_ff    <= u_in;
         v_ff    <= v_in;
         m_sx_ff <= m_sx_in;
         m_sy_ff <= m_sy_in;
         k_sx_ff <= k_sx_in;
         k_sy_ff <= k_sy_in;
         rsp_fill_ff <= empty;
         rsp_sx_ff   <= empty ? '0 : k_sx_ff;
         rsp_sy_ff   <= empty ? '0 : k_sy_ff;
         rsp_ofs_ff  <= empty ? '0 : rsp_ofs_in;
      end
   end

   assign rsp_source_x     = rsp_sx_ff;
   assign rsp_source_y     = rsp_sy_ff;
   assign rsp_pixel_offset = rsp_ofs_ff;
   assign rsp_fill_black   = rsp_fill_ff;

`ifndef NO_ASSERTIONS
   // a black fill carries no coordinates
   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fill_black |->
         rsp_source_x == '0 && rsp_source_y == '0 && rsp_pixel_offset == '0)
      else $error("fill response with nonzero coordinates");

   // an accepted request occupies the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted request lost at pipeline entry");

   // a stalled response keeps the pipe frozen
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(vld_ff))
      else $error("pipeline moved during output stall");
`endif

endmodule

// ===== test/cubemap_face_to_panorama_sampler_test.sv =====
// ---------------------------------------------------------------------------
// cubemap_face_to_panorama_sampler_test
// Drives face/pixel requests through several source sizes and checks every
// response against an in-bench model of the face mapping and the CORDIC.
// ---------------------------------------------------------------------------
module cubemap_face_to_panorama_sampler_test;
   import cfps_pkg::*;

   localparam logic [FACE_W-1:0] FACE_SPARE_LO = 3'd6;
   localparam logic [FACE_W-1:0] FACE_SPARE_HI = 3'd7;
   localparam logic [IDX_W-1:0]  REG_SPARE     = 2'd3;
   localparam int                SETTLE        = PIPE_DEPTH + 8;

   typedef struct packed {
      logic [SRC_W-1:0] sx;
      logic [SRC_W-1:0] sy;
      logic [OFS_W-1:0] ofs;
      logic             black;
   } sample_type;

   // expected samples and the sampler model
   class sample_board;
      sample_type expected [$];
      logic [DIM_W-1:0] width_reg, height_reg;
      int errors;

      function new();
         width_reg = '0; height_reg = '0; errors = 0;
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
         if (idx == REG_SOURCE_WIDTH) width_reg = data;
         else if (idx == REG_SOURCE_HEIGHT) height_reg = data;
      endfunction

      // append one expected sample at the tail
      function void queue_sample(sample_type s);
         expected = {expected, s};
      endfunction

      function longint floor_root(longint unsigned s);
         longint unsigned res, bit_v;
         res = 0; bit_v = 64'd1 << 62;
         while (bit_v > s) bit_v >>= 2;
         while (bit_v != 0) begin
            if (s >= res + bit_v) begin
               s -= res + bit_v;
               res = (res >> 1) + bit_v;
            end else begin
               res >>= 1;
            end
            bit_v >>= 2;
         end
         return longint'(res);
      endfunction

      // binary angle of (x, y), 2^32 per turn
      function longint angle_of(longint y, longint x);
         longint z, t, xs, ys;
         z = 0;
         if (x == 0 && y == 0) return 0;
         x = x * 4096; y = y * 4096;
         if (x < 0) begin
            if (y >= 0) begin t = x; x = y; y = -t; z = 64'sd1073741824; end
            else begin t = x; x = -y; y = t; z = -64'sd1073741824; end
         end
         for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (y > 0) begin x += ys; y -= xs; z += longint'(ATAN_TURNS[i]); end
            else begin x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]); end
         end
         return z;
      endfunction

      function longint face_pos(longint p, longint f);
         if (p >= f) p = f - 1;
         return ((2 * p + 1) << 16) / f - 65536;
      endfunction

      function void note_request(logic [FACE_W-1:0] face, logic [PIX_W-1:0] px,
                                 logic [PIX_W-1:0] py);
         sample_type s;
         longint w, h, f, fx, fy, dx, dy, dz, r, az, el, v;
         longint unsigned u, sx, sy;
         w = width_reg; h = height_reg;
         if (w == 0 || h == 0) begin
            s = '{sx: 0, sy: 0, ofs: 0, black: 1'b1};
            queue_sample(s);
            return;
         end
         if (w > 8192) w = 8192;
         if (h > 8192) h = 8192;
         f = height_reg;
         if (f < 64) f = 64;
         if (f > 1024) f = 1024;
         fx = face_pos(px, f); fy = face_pos(py, f);
         case (face)
            FACE_POS_X: begin dx = 65536;  dy = -fy;    dz = -fx;    end
            FACE_NEG_X: begin dx = -65536; dy = -fy;    dz = fx;     end
            FACE_POS_Y: begin dx = fx;     dy = 65536;  dz = fy;     end
            FACE_NEG_Y: begin dx = fx;     dy = -65536; dz = -fy;    end
            FACE_POS_Z: begin dx = fx;     dy = -fy;    dz = 65536;  end
            default:    begin dx = -fx;    dy = -fy;    dz = -65536; end
         endcase
         r  = floor_root(dx * dx + dz * dz);
         az = angle_of(dx, dz);
         el = angle_of(dy, r);
         u  = (longint'(az) + 64'sd2147483648) & 64'hFFFF_FFFF;
         v  = 64'sd2147483648 - 2 * el;
         if (v < 0) v = 0;
         if (v > 64'sd4294967296) v = 64'sd4294967296;
         sx = (u * w) >> 32;
         if (sx > w - 1) sx = w - 1;
         sy = (unsigned'(v) * h) >> 32;
         if (sy > h - 1) sy = h - 1;
         s.sx = sx[SRC_W-1:0];
         s.sy = sy[SRC_W-1:0];
         s.ofs = OFS_W'(sy * w + sx);
         s.black = 1'b0;
         queue_sample(s);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_response(sample_type got);
         sample_type want;
         if (expected.size() == 0) begin
            report("unexpected response", 1, 0);
            return;
         end
         want = expected.pop_front();
         if (got.sx != want.sx) report("source_x", got.sx, want.sx);
         if (got.sy != want.sy) report("source_y", got.sy, want.sy);
         if (got.ofs != want.ofs) report("pixel_offset", got.ofs, want.ofs);
         if (got.black != want.black) report("fill_black", got.black, want.black);
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0, req_ready;
   logic [FACE_W-1:0] req_face = '0;
   logic [PIX_W-1:0] req_pixel_x = '0, req_pixel_y = '0;
   logic             rsp_valid, rsp_ready = 1'b0;
   logic [SRC_W-1:0] rsp_source_x, rsp_source_y;
   logic [OFS_W-1:0] rsp_pixel_offset;
   logic             rsp_fill_black;
   logic             csr_valid = 1'b0, csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0] csr_data = '0;

   sample_board board = new();
   bit  busy_mode = 1'b0;   // no idling on either side
   int  rsp_hold = 0;       // cycles the receiver still holds off

   cubemap_face_to_panorama_sampler DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: check on handshake, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response('{rsp_source_x, rsp_source_y, rsp_pixel_offset,
                                rsp_fill_black});
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= busy_mode || ($urandom_range(0, 99) >= 38);
      end
   end

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(logic [FACE_W-1:0] face, logic [PIX_W-1:0] px,
                               logic [PIX_W-1:0] py);
      if (!busy_mode) begin
         while ($urandom_range(0, 99) < 38) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1; req_face <= face; req_pixel_x <= px; req_pixel_y <= py;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(face, px, py);
   endtask

   // wait for all responses, then let the pipe settle before a csr write
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_requests(int count);
      int fsz, lim;
      fsz = board.height_reg < 64 ? 64 : (board.height_reg > 1024 ? 1024
                                                                  : board.height_reg);
      for (int n = 0; n < count; n++) begin
         lim = ($urandom_range(0, 99) < 85) ? fsz - 1 : 1023;
         send_request(($urandom_range(0, 9) == 0) ? FACE_W'($urandom_range(6, 7))
                                                  : FACE_W'($urandom_range(0, 5)),
                      PIX_W'($urandom_range(0, lim)), PIX_W'($urandom_range(0, lim)));
      end
   endtask

   initial begin
      #2000000;
      $display("cubemap_face_to_panorama_sampler_test failed");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty source straight out of reset
      send_request(FACE_POS_X, 10'd0, 10'd0);
      send_request(FACE_NEG_Z, 10'd1023, 10'd1023);
      drain();

      // directed: full face size, two corners and the center of every face, then spare csr index and face codes
      write_reg(REG_SOURCE_WIDTH, 14'd4096);
      write_reg(REG_SOURCE_HEIGHT, 14'd1024);
      write_reg(REG_SPARE, 14'd7);
      for (int fc = 0; fc < 6; fc++) begin
         send_request(FACE_W'(fc), 10'd0, 10'd0);
         send_request(FACE_W'(fc), 10'd1023, 10'd1023);
         send_request(FACE_W'(fc), 10'd511, 10'd512);
      end
      send_request(FACE_SPARE_LO, 10'd100, 10'd900);
      send_request(FACE_SPARE_HI, 10'd1023, 10'd0);
      drain();

      // odd face size: face center on +Y/-Y gives a zero azimuth vector
      write_reg(REG_SOURCE_HEIGHT, 14'd65);
      send_request(FACE_POS_Y, 10'd32, 10'd32);
      send_request(FACE_NEG_Y, 10'd32, 10'd32);
      send_request(FACE_POS_Z, 10'd1023, 10'd700);   // beyond the face
      random_requests(100);
      drain();

      // oversized source, no idling, long receiver hold-off
      write_reg(REG_SOURCE_WIDTH, 14'd16383);
      write_reg(REG_SOURCE_HEIGHT, 14'd16383);
      busy_mode = 1'b1;
      rsp_hold = 300;
      random_requests(250);
      busy_mode = 1'b0;
      drain();

      // tiny source: one pixel
      write_reg(REG_SOURCE_WIDTH, 14'd1);
      write_reg(REG_SOURCE_HEIGHT, 14'd1);
      random_requests(100);
      drain();

      // one dimension empty
      write_reg(REG_SOURCE_HEIGHT, 14'd0);
      write_reg(REG_SOURCE_WIDTH, 14'd512);
      random_requests(60);
      drain();
      write_reg(REG_SOURCE_HEIGHT, 14'd512);
      write_reg(REG_SOURCE_WIDTH, 14'd0);
      random_requests(60);
      drain();

      // assorted sizes
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_SOURCE_WIDTH, DIM_W'($urandom_range(1, 8192)));
         write_reg(REG_SOURCE_HEIGHT, DIM_W'($urandom_range(1, 2048)));
         random_requests(140);
         drain();
      end

      if (board.errors == 0 && board.expected.size() == 0)
         $display("cubemap_face_to_panorama_sampler_test passed");
      else
         $display("cubemap_face_to_panorama_sampler_test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cfps_pkg.sv
rtl/cubemap_face_to_panorama_sampler.sv
test/cubemap_face_to_panorama_sampler_test.sv
